[hw/rtl/base64_line_wrapped_encoder_assert.svh]
// assertion macros for the base64 line wrapped encoder
`ifndef BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define B64_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/b64lw_pkg.sv]
// shared types, constants and the alphabet function of the base64 line wrapped encoder
package b64lw_pkg;

  localparam logic [7:0] LINE_LIMIT_RST = 8'd76;
  localparam logic [7:0] PAD_CHAR       = 8'h3D;
  localparam logic [7:0] CR_CHAR        = 8'h0D;
  localparam logic [7:0] LF_CHAR        = 8'h0A;
  localparam logic [7:0] PLUS_CHAR      = 8'h2B;
  localparam logic [7:0] SLASH_CHAR     = 8'h2F;
  localparam logic [7:0] UPPER_A        = 8'h41;
  localparam logic [7:0] LOWER_A        = 8'h61;
  localparam logic [7:0] DIGIT_0        = 8'h30;

  // last character index of a group: four or six characters
  localparam logic [2:0] IDX_FOUR = 3'd3;
  localparam logic [2:0] IDX_SIX  = 3'd5;

  // bytes held from the current group
  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  // one group of characters handed from the grouper to the emitter
  typedef struct packed {
    logic [5:0][7:0] chars;
    logic [2:0]      last_idx;
    logic            fin;
  } grp_t;

  // six-bit value to its alphabet character
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = DIGIT_0 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

[hw/rtl/b64lw_in_if.sv]
// input channel: one raw byte per beat with an end-of-message flag
interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/b64lw_out_if.sv]
// result channel: one encoded character per beat with an end-of-message flag
interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

[hw/rtl/base64_line_wrapped_encoder.sv]
// Base64 encoder with CR LF line wrapping: one raw byte per input beat, one ASCII
// character per output beat. The byte that closes a group is turned into a registered
// group of four characters (six with a CR LF) as it is taken, and the emitter then plays
// it out at one character per cycle while the receiver keeps ready high, a rate that the
// single-character output port sets. The input keeps taking bytes while one group drains;
// once a second group waits behind it, the input stalls until the emitter takes that
// group, so the output side runs without bubbles and the input follows its pace. The user
// must write line_limit (reset 76) through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce it. Padded final groups never get a line break.
module base64_line_wrapped_encoder (
  input  logic        clk,
  input  logic        rst_n,
  b64lw_in_if.sink    in_bus,
  b64lw_out_if.source out_bus,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import b64lw_pkg::*;

  logic grp_valid;
  logic grp_ready;
  grp_t grp;

  // grouping and line tracking
  b64lw_group u_group (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  // character output
  b64lw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_bus   (out_bus)
  );

endmodule

[hw/rtl/b64lw_group.sv]
// byte grouper: collects bytes, tracks the line, and builds one registered character group
module b64lw_group (
  input  logic                 clk,
  input  logic                 rst_n,
  b64lw_in_if.sink             in_bus,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  output logic                 grp_valid,
  input  logic                 grp_ready,
  output b64lw_pkg::grp_t      grp
);
  import b64lw_pkg::*;

  `include "base64_line_wrapped_encoder_assert.svh"

  phase_t      phase_r, phase_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [7:0]  line_cnt_r, line_cnt_nxt;
  logic [7:0]  line_limit_r;
  logic        grp_valid_r, grp_valid_nxt;
  grp_t        grp_r, grp_nxt;
  logic        accept;
  logic        emit;
  logic [8:0]  sum;
  logic        brk;
  logic [7:0]  b0, b1, b;

  assign in_bus.ready = !grp_valid_r || grp_ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign grp_valid    = grp_valid_r;
  assign grp          = grp_r;

  assign b0  = pend_r[15:8];
  assign b1  = pend_r[7:0];
  assign b   = in_bus.data_byte;
  assign sum = {1'b0, line_cnt_r} + 9'd4;
  assign brk = sum >= {1'b0, line_limit_r};

  // line limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LINE_LIMIT_RST;
    end else if (cfg_we) begin
      line_limit_r <= cfg_wdata;
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ZERO;
      pend_r     <= '0;
      line_cnt_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pend_r     <= pend_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  // next state and the character group for the current beat
  always_comb begin
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    line_cnt_nxt = line_cnt_r;
    emit         = 1'b0;
    grp_nxt      = grp_r;
    case (phase_r)
      PH_TWO: begin
        emit             = 1'b1;
        grp_nxt.chars[0] = sym(b0[7:2]);
        grp_nxt.chars[1] = sym({b0[1:0], b1[7:4]});
        grp_nxt.chars[2] = sym({b1[3:0], b[7:6]});
        grp_nxt.chars[3] = sym(b[5:0]);
        grp_nxt.chars[4] = CR_CHAR;
        grp_nxt.chars[5] = LF_CHAR;
        grp_nxt.last_idx = brk ? IDX_SIX : IDX_FOUR;
        grp_nxt.fin      = in_bus.last_byte;
        phase_nxt        = PH_ZERO;
        pend_nxt         = '0;
        line_cnt_nxt     = (brk || in_bus.last_byte) ? 8'd0 : sum[7:0];
      end
      PH_ONE: begin
        if (in_bus.last_byte) begin
          emit             = 1'b1;
          grp_nxt.chars[0] = sym(b1[7:2]);
          grp_nxt.chars[1] = sym({b1[1:0], b[7:4]});
          grp_nxt.chars[2] = sym({b[3:0], 2'b00});
          grp_nxt.chars[3] = PAD_CHAR;
          grp_nxt.chars[4] = CR_CHAR;
          grp_nxt.chars[5] = LF_CHAR;
          grp_nxt.last_idx = IDX_FOUR;
          grp_nxt.fin      = 1'b1;
          phase_nxt        = PH_ZERO;
          pend_nxt         = '0;
          line_cnt_nxt     = '0;
        end else begin
          phase_nxt = PH_TWO;
          pend_nxt  = {b1, b};
        end
      end
      default: begin
        if (in_bus.last_byte) begin
          emit             = 1'b1;
          grp_nxt.chars[0] = sym(b[7:2]);
          grp_nxt.chars[1] = sym({b[1:0], 4'b0000});
          grp_nxt.chars[2] = PAD_CHAR;
          grp_nxt.chars[3] = PAD_CHAR;
          grp_nxt.chars[4] = CR_CHAR;
          grp_nxt.chars[5] = LF_CHAR;
          grp_nxt.last_idx = IDX_FOUR;
          grp_nxt.fin      = 1'b1;
          phase_nxt        = PH_ZERO;
          pend_nxt         = '0;
          line_cnt_nxt     = '0;
        end else begin
          phase_nxt = PH_ONE;
          pend_nxt  = {8'h00, b};
        end
      end
    endcase
  end

  // group output register, held until the emitter takes it
  assign grp_valid_nxt = (grp_valid_r && !grp_ready) || (accept && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      grp_r <= grp_nxt;
    end
  end

  `B64_ASSERT_NEXT(a_last_clears, accept && in_bus.last_byte,
    phase_r == PH_ZERO && line_cnt_r == 8'd0, "state not cleared after last byte")
  `B64_ASSERT_NOW(a_cnt_aligned, 1'b1, line_cnt_r[1:0] == 2'b00,
    "line count not a multiple of four")
  `B64_ASSERT_NEXT(a_grp_held, grp_valid_r && !grp_ready, grp_valid_r && $stable(grp_r),
    "pending group dropped or changed")

endmodule

[hw/rtl/b64lw_emit.sv]
// character emitter: plays one group out on the result channel, one character per beat
module b64lw_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 grp_valid,
  output logic                 grp_ready,
  input  b64lw_pkg::grp_t      grp,
  b64lw_out_if.source          out_bus
);
  import b64lw_pkg::*;

  `include "base64_line_wrapped_encoder_assert.svh"

  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  grp_t       buf_r;
  logic       at_end;
  logic       take;
  logic       load;

  assign at_end    = idx_r == buf_r.last_idx;
  assign take      = out_bus.valid && out_bus.ready;
  assign grp_ready = !busy_r || (take && at_end);
  assign load      = grp_valid && grp_ready;

  assign out_bus.valid     = busy_r;
  assign out_bus.out_char  = buf_r.chars[idx_r];
  assign out_bus.last_char = buf_r.fin && at_end;

  // character pointer and busy flag
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (take) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // group buffer
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= grp;
    end
  end

  `B64_ASSERT_NOW(a_idx_range, busy_r, idx_r <= buf_r.last_idx,
    "character pointer past end of group")
  `B64_ASSERT_NEXT(a_grp_size, load, buf_r.last_idx == IDX_FOUR || buf_r.last_idx == IDX_SIX,
    "group loaded with bad length")
  `B64_ASSERT_NEXT(a_drain, take && at_end && !grp_valid, !busy_r,
    "emitter stays busy after final character")

endmodule

[test/base64_line_wrapped_encoder_test.sv]
// self-checking testbench for the base64 line wrapped encoder, driven through its channels
module base64_line_wrapped_encoder_test;
  import b64lw_pkg::*;

  localparam int          HALF_PERIOD   = 2;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_OFF      = 80;
  localparam int          LONG_MSG      = 195;
  localparam int          RANDOM_ITEMS  = 330;
  localparam int          IDLE_PCT      = 30;
  localparam int          RUN_LIMIT     = 200000 * 2 * HALF_PERIOD;
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // one encoded character with its end-of-message flag
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  // directed row: a message byte or a line limit write
  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  value;
    logic        fin;
    logic [31:0] text;
    logic [2:0]  n_typed;
  } row_t;

  // typed text is given only where the characters are obvious
  localparam row_t DIRECTED_ROWS [25] = '{
    '{ROW_BYTE,  8'h00, 1'b1, "AA==", 3'd4},
    '{ROW_BYTE,  8'hFF, 1'b1, "/w==", 3'd4},
    '{ROW_BYTE,  8'hFF, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'hFF, 1'b1, "//8=", 3'd4},
    '{ROW_BYTE,  8'h00, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h00, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h00, 1'b1, "AAAA", 3'd4},
    '{ROW_BYTE,  8'hFF, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'hFF, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'hFF, 1'b1, "////", 3'd4},
    '{ROW_BYTE,  8'h4D, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h61, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h6E, 1'b0, "TWFu", 3'd4},
    // limit dropped to zero with four characters already on the line
    '{ROW_LIMIT, 8'd0,  1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h00, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h10, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h83, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h80, 1'b1, "gA==", 3'd4},
    // limit that is not a multiple of four
    '{ROW_LIMIT, 8'd5,  1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'hFB, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'hEF, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'hBE, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h01, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h23, 1'b0, 32'h0,  3'd0},
    '{ROW_BYTE,  8'h45, 1'b1, 32'h0,  3'd0}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  b64lw_in_if  in_bus ();
  b64lw_out_if out_bus ();

  base64_line_wrapped_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // encoder state as the testbench sees it
  logic [7:0]  line_limit = LINE_LIMIT_RST;
  logic [15:0] held_bytes = '0;
  phase_t      held_count = PH_ZERO;
  logic [7:0]  line_count = '0;

  enc_char_t encoded_text [$];
  enc_char_t fresh_chars [$];
  int        mismatches    = 0;
  bit        calm          = 1'b0;
  bit        stall_request = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [7:0] letter(input logic [5:0] v);
    return ALPHABET[8 * (63 - int'(v)) +: 8];
  endfunction

  // append one character to the expected stream
  function automatic void queue_expected(input enc_char_t c);
    encoded_text = {encoded_text, c};
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic fin);
    enc_char_t c;
    c.ch  = ch;
    c.fin = fin;
    fresh_chars = {fresh_chars, c};
  endfunction

  // characters caused by one accepted byte, state updated in place
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [8:0] reach;
    logic       wrap;
    case (held_count)
      PH_TWO: begin
        b0 = held_bytes[15:8];
        b1 = held_bytes[7:0];
        reach = {1'b0, line_count} + 9'd4;
        wrap = reach >= {1'b0, line_limit};
        emit(letter(b0[7:2]), 1'b0);
        emit(letter({b0[1:0], b1[7:4]}), 1'b0);
        emit(letter({b1[3:0], b[7:6]}), 1'b0);
        emit(letter(b[5:0]), fin && !wrap);
        if (wrap) begin
          emit(CR_CHAR, 1'b0);
          emit(LF_CHAR, fin);
          line_count = '0;
        end else begin
          line_count = reach[7:0];
        end
        held_bytes = '0;
        held_count = PH_ZERO;
        if (fin) line_count = '0;
      end
      PH_ONE: begin
        b0 = held_bytes[7:0];
        if (fin) begin
          emit(letter(b0[7:2]), 1'b0);
          emit(letter({b0[1:0], b[7:4]}), 1'b0);
          emit(letter({b[3:0], 2'b00}), 1'b0);
          emit(PAD_CHAR, 1'b1);
          held_bytes = '0;
          held_count = PH_ZERO;
          line_count = '0;
        end else begin
          held_bytes = {b0, b};
          held_count = PH_TWO;
        end
      end
      default: begin
        if (fin) begin
          emit(letter(b[7:2]), 1'b0);
          emit(letter({b[1:0], 4'b0000}), 1'b0);
          emit(PAD_CHAR, 1'b0);
          emit(PAD_CHAR, 1'b1);
          held_bytes = '0;
          held_count = PH_ZERO;
          line_count = '0;
        end else begin
          held_bytes = {8'h00, b};
          held_count = PH_ONE;
        end
      end
    endcase
  endfunction

  // offer one byte beat, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic [31:0] text,
                           input int n_typed);
    int        k;
    enc_char_t c;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    fresh_chars.delete();
    encode_byte(b, fin);
    if (n_typed == 0) begin
      for (k = 0; k < fresh_chars.size(); k++) queue_expected(fresh_chars[k]);
    end else begin
      for (k = 0; k < n_typed; k++) begin
        c.ch  = text[8 * (3 - k) +: 8];
        c.fin = fin && (k == n_typed - 1);
        queue_expected(c);
      end
    end
    @(negedge clk);
  endtask

  // line limit write once the block has gone quiet
  task automatic set_line_limit(input logic [7:0] v);
    in_bus.valid <= 1'b0;
    while (encoded_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    line_limit = v;
    @(negedge clk);
  endtask

  // receiver: random ready, with one long hold-off on request
  initial begin : char_sink
    int n;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        for (n = 0; n < HOLD_OFF; n++) begin
          out_bus.ready <= 1'b0;
          @(negedge clk);
        end
        stall_request = 1'b0;
      end
      out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // compare each character beat with the oldest prediction
  always @(posedge clk) begin : char_check
    enc_char_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (encoded_text.size() == 0) begin
        flag_mismatch($sformatf("character %h with nothing expected", out_bus.out_char));
      end else begin
        want = encoded_text.pop_front();
        if (out_bus.out_char !== want.ch)
          flag_mismatch($sformatf("out_char %h, want %h", out_bus.out_char, want.ch));
        if (out_bus.last_char !== want.fin)
          flag_mismatch($sformatf("last_char %b, want %b on %h", out_bus.last_char,
                                  want.fin, want.ch));
      end
    end
  end

  initial begin : stimulus
    int         r;
    int         k;
    int         sent;
    int         budget;
    int         phase_no;
    logic [7:0] lim;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_LIMIT) begin
        set_line_limit(DIRECTED_ROWS[r].value);
      end else begin
        send_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].fin, DIRECTED_ROWS[r].text,
                  int'(DIRECTED_ROWS[r].n_typed));
      end
    end

    // one long message at the widest limit, receiver held off at its start
    set_line_limit(8'd255);
    stall_request = 1'b1;
    for (k = 0; k < LONG_MSG; k++) begin
      send_byte(8'($urandom_range(0, 255)), k == LONG_MSG - 1, 32'h0, 0);
    end
    sent = LONG_MSG;

    // short messages under changing limits, phases may end mid-message
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: lim = 8'd0;
        1: lim = 8'd4;
        2: lim = 8'd252;
        3: lim = 8'd253;
        4: lim = LINE_LIMIT_RST;
        5: lim = {6'($urandom_range(1, 63)), 2'b00};
        default: lim = 8'($urandom_range(0, 255));
      endcase
      set_line_limit(lim);
      calm = (phase_no == 2);
      budget = calm ? 40 : $urandom_range(15, 35);
      for (k = 0; k < budget; k++) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 32'h0, 0);
      end
      calm = 1'b0;
      sent += budget;
      phase_no++;
    end

    // drain
    in_bus.valid <= 1'b0;
    while (encoded_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/b64lw_pkg.sv
hw/rtl/b64lw_in_if.sv
hw/rtl/b64lw_out_if.sv
hw/rtl/b64lw_group.sv
hw/rtl/b64lw_emit.sv
hw/rtl/base64_line_wrapped_encoder.sv
test/base64_line_wrapped_encoder_test.sv
